@@ rtl/vrp_pkg.sv @@
// shared types and constants for the vram register port
package vrp_pkg;

  localparam int XR_DEPTH_DEF   = 256;
  localparam int VRAM_WORDS_DEF = 65536;
  localparam int DATA_W         = 16;

  typedef enum logic [2:0] {
    CMD_RD16  = 3'd0,
    CMD_WR16  = 3'd1,
    CMD_RD_HI = 3'd2,
    CMD_RD_LO = 3'd3,
    CMD_XR_RD = 3'd4,
    CMD_XR_WR = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    REG_SYS_CTRL = 4'd0,
    REG_INT_CTRL = 4'd1,
    REG_TIMER    = 4'd2,
    REG_RD_XADDR = 4'd3,
    REG_WR_XADDR = 4'd4,
    REG_XDATA    = 4'd5,
    REG_RD_INCR  = 4'd6,
    REG_RD_ADDR  = 4'd7,
    REG_WR_INCR  = 4'd8,
    REG_WR_ADDR  = 4'd9,
    REG_DATA     = 4'd10,
    REG_DATA_2   = 4'd11,
    REG_PIXEL_X  = 4'd12,
    REG_PIXEL_Y  = 4'd13,
    REG_UART     = 4'd14,
    REG_FEATURE  = 4'd15
  } reg_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WO    = 2'd1,
    ST_UNIMP = 2'd2,
    ST_RO    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_VALUE = 2'd0,
    SRC_XR    = 2'd1,
    SRC_VRAM  = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    BM_WORD = 2'd0,
    BM_HI   = 2'd1,
    BM_LO   = 2'd2
  } bmode_t;

  typedef struct packed {
    src_t              src;
    bmode_t            bmode;
    logic [DATA_W-1:0] value;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [15:0]       rd_addr;
    logic              wr_en;
    logic [15:0]       wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

endpackage

@@ rtl/vrp_if.sv @@
// handshake channels for commands and results
interface vrp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] reg_number;
  logic [15:0] write_value;

  modport source (output valid, cmd, reg_number, write_value, input ready);
  modport sink (input valid, cmd, reg_number, write_value, output ready);
endinterface

interface vrp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [1:0]  status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

@@ rtl/vram_register_port_autoinc_core.sv @@
// top level of the host register window with auto-increment data ports
// a result is valid in the cycle after its command transfer
// one command per cycle unless clearing; ready follows rsp.ready combinationally
// memory reads come from registered ports of the extended store and video memory
// reset: control registers and feature word clear at once, then the extended
// store is swept to zero word by word while no command is taken
module vram_register_port_autoinc_core
  import vrp_pkg::*;
#(
  parameter int XR_DEPTH   = XR_DEPTH_DEF,
  parameter int VRAM_WORDS = VRAM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  vrp_in_if.sink      req,
  vrp_out_if.source   rsp
);

  logic              accept;
  logic              xr_busy;
  res_t              res;
  mem_req_t          xr_req, vr_req;
  logic [DATA_W-1:0] xr_rdata, vr_rdata;

  assign req.ready = !xr_busy && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  vrp_regs #(.XR_DEPTH(XR_DEPTH)) u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .cmd         (req.cmd),
    .reg_number  (req.reg_number),
    .write_value (req.write_value),
    .res         (res),
    .xr_req      (xr_req),
    .vr_req      (vr_req)
  );

  vrp_xr_mem #(.XR_DEPTH(XR_DEPTH)) u_xr (
    .clk   (clk),
    .rst   (rst),
    .req   (xr_req),
    .busy  (xr_busy),
    .rdata (xr_rdata)
  );

  vrp_vram #(.VRAM_WORDS(VRAM_WORDS)) u_vram (
    .clk   (clk),
    .req   (vr_req),
    .rdata (vr_rdata)
  );

  vrp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .xr_rdata (xr_rdata),
    .vr_rdata (vr_rdata),
    .rsp      (rsp)
  );

  a_no_transfer_while_clearing: assert property (@(posedge clk) disable iff (rst)
    xr_busy |-> !req.ready)
    else $error("command taken during store clear");

  a_result_follows_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("no result after command transfer");

  a_rejected_read_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_WO || rsp.status == ST_RO)) |-> rsp.read_data == '0)
    else $error("rejected access returned data");

  a_mem_access_single: assert property (@(posedge clk) disable iff (rst)
    (xr_req.rd_en || xr_req.wr_en || vr_req.rd_en || vr_req.wr_en) |-> accept)
    else $error("memory access without command transfer");

endmodule

@@ rtl/vrp_regs.sv @@
// register file and access decode for the host register window
module vrp_regs
  import vrp_pkg::*;
#(
  parameter int XR_DEPTH = XR_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic [2:0]  cmd,
  input  logic [15:0] reg_number,
  input  logic [15:0] write_value,
  output res_t        res,
  output mem_req_t    xr_req,
  output mem_req_t    vr_req
);

  logic [15:0] feature_word;
  logic [15:0] sys_ctrl, int_ctrl, timer, rd_xaddr, wr_xaddr;
  logic [15:0] rd_incr, rd_addr, wr_incr, wr_addr, pixel_x, pixel_y;
  logic [15:0] sys_ctrl_next, int_ctrl_next, timer_next, rd_xaddr_next, wr_xaddr_next;
  logic [15:0] rd_incr_next, rd_addr_next, wr_incr_next, wr_addr_next;
  logic [15:0] pixel_x_next, pixel_y_next;

  reg_t        r;
  logic [15:0] slot_val;
  mem_req_t    xr_raw, vr_raw;

  function automatic logic xr_ok(input logic [15:0] a);
    return {1'b0, a} < 17'(XR_DEPTH);
  endfunction

  assign r = reg_t'(reg_number[3:0]);

  always_comb begin
    slot_val = '0;
    unique case (r)
      REG_SYS_CTRL: slot_val = sys_ctrl;
      REG_INT_CTRL: slot_val = int_ctrl;
      REG_TIMER:    slot_val = timer;
      REG_RD_XADDR: slot_val = rd_xaddr;
      REG_WR_XADDR: slot_val = wr_xaddr;
      REG_RD_INCR:  slot_val = rd_incr;
      REG_RD_ADDR:  slot_val = rd_addr;
      REG_WR_INCR:  slot_val = wr_incr;
      REG_WR_ADDR:  slot_val = wr_addr;
      REG_PIXEL_X:  slot_val = pixel_x;
      REG_PIXEL_Y:  slot_val = pixel_y;
      default:      slot_val = '0;
    endcase
  end

  always_comb begin
    res           = '{src: SRC_VALUE, bmode: BM_WORD, value: '0, status: ST_OK};
    xr_raw        = '0;
    vr_raw        = '0;
    sys_ctrl_next = sys_ctrl;
    int_ctrl_next = int_ctrl;
    timer_next    = timer;
    rd_xaddr_next = rd_xaddr;
    wr_xaddr_next = wr_xaddr;
    rd_incr_next  = rd_incr;
    rd_addr_next  = rd_addr;
    wr_incr_next  = wr_incr;
    wr_addr_next  = wr_addr;
    pixel_x_next  = pixel_x;
    pixel_y_next  = pixel_y;

    unique case (cmd)
      CMD_RD16, CMD_RD_HI, CMD_RD_LO: begin
        res.bmode = (cmd == CMD_RD_HI) ? BM_HI : (cmd == CMD_RD_LO) ? BM_LO : BM_WORD;
        case (r) inside
          REG_PIXEL_X, REG_PIXEL_Y: res.status = ST_WO;
          REG_UART:                 res.status = ST_UNIMP;
          REG_FEATURE:              res.value  = feature_word;
          REG_XDATA: begin
            if (cmd == CMD_RD16) begin
              rd_xaddr_next = rd_xaddr + 16'd1;
              if (xr_ok(rd_xaddr)) begin
                res.src        = SRC_XR;
                xr_raw.rd_en   = 1'b1;
                xr_raw.rd_addr = rd_xaddr;
              end else begin
                res.status = ST_UNIMP;
              end
            end
          end
          REG_DATA, REG_DATA_2: begin
            if (cmd == CMD_RD16) begin
              res.src        = SRC_VRAM;
              vr_raw.rd_en   = 1'b1;
              vr_raw.rd_addr = rd_addr;
              rd_addr_next   = rd_addr + rd_incr;
            end
          end
          default: res.value = slot_val;
        endcase
      end
      CMD_WR16: begin
        case (r) inside
          REG_SYS_CTRL: sys_ctrl_next = write_value;
          REG_INT_CTRL: int_ctrl_next = write_value;
          REG_TIMER:    timer_next    = write_value;
          REG_RD_XADDR: rd_xaddr_next = write_value;
          REG_WR_XADDR: wr_xaddr_next = write_value;
          REG_RD_INCR:  rd_incr_next  = write_value;
          REG_RD_ADDR:  rd_addr_next  = write_value;
          REG_WR_INCR:  wr_incr_next  = write_value;
          REG_WR_ADDR:  wr_addr_next  = write_value;
          REG_PIXEL_X:  pixel_x_next  = write_value;
          REG_PIXEL_Y:  pixel_y_next  = write_value;
          REG_XDATA: begin
            wr_xaddr_next = wr_xaddr + 16'd1;
            if (xr_ok(wr_xaddr)) begin
              xr_raw.wr_en   = 1'b1;
              xr_raw.wr_addr = wr_xaddr;
              xr_raw.wr_data = write_value;
            end else begin
              res.status = ST_UNIMP;
            end
          end
          REG_DATA, REG_DATA_2: begin
            vr_raw.wr_en   = 1'b1;
            vr_raw.wr_addr = wr_addr;
            vr_raw.wr_data = write_value;
            wr_addr_next   = wr_addr + wr_incr;
          end
          REG_UART: res.status = ST_UNIMP;
          default:  res.status = ST_RO;
        endcase
      end
      CMD_XR_RD: begin
        if (xr_ok(reg_number)) begin
          res.src        = SRC_XR;
          xr_raw.rd_en   = 1'b1;
          xr_raw.rd_addr = reg_number;
        end else begin
          res.status = ST_UNIMP;
        end
      end
      CMD_XR_WR: begin
        if (xr_ok(reg_number)) begin
          xr_raw.wr_en   = 1'b1;
          xr_raw.wr_addr = reg_number;
          xr_raw.wr_data = write_value;
        end else begin
          res.status = ST_UNIMP;
        end
      end
      default: res.status = ST_UNIMP;
    endcase
  end

  always_comb begin
    xr_req       = xr_raw;
    xr_req.rd_en = xr_raw.rd_en & accept;
    xr_req.wr_en = xr_raw.wr_en & accept;
    vr_req       = vr_raw;
    vr_req.rd_en = vr_raw.rd_en & accept;
    vr_req.wr_en = vr_raw.wr_en & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_word <= '0;
    end else if (cfg_we) begin
      feature_word <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_ctrl <= '0;
      int_ctrl <= '0;
      timer    <= '0;
      rd_xaddr <= '0;
      wr_xaddr <= '0;
      rd_incr  <= '0;
      rd_addr  <= '0;
      wr_incr  <= '0;
      wr_addr  <= '0;
      pixel_x  <= '0;
      pixel_y  <= '0;
    end else if (accept) begin
      sys_ctrl <= sys_ctrl_next;
      int_ctrl <= int_ctrl_next;
      timer    <= timer_next;
      rd_xaddr <= rd_xaddr_next;
      wr_xaddr <= wr_xaddr_next;
      rd_incr  <= rd_incr_next;
      rd_addr  <= rd_addr_next;
      wr_incr  <= wr_incr_next;
      wr_addr  <= wr_addr_next;
      pixel_x  <= pixel_x_next;
      pixel_y  <= pixel_y_next;
    end
  end

endmodule

@@ rtl/vrp_xr_mem.sv @@
// extended register store with clearing sweep after reset
module vrp_xr_mem
  import vrp_pkg::*;
#(
  parameter int XR_DEPTH = XR_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_req_t          req,
  output logic              busy,
  output logic [DATA_W-1:0] rdata
);

  localparam int XA_W = $clog2(XR_DEPTH);

  logic [DATA_W-1:0] mem [XR_DEPTH];
  logic [XA_W-1:0]   clr_addr;
  logic              clearing;
  logic              we;
  logic [XA_W-1:0]   waddr;
  logic [DATA_W-1:0] wdata;

  assign busy  = clearing;
  assign we    = clearing | req.wr_en;
  assign waddr = clearing ? clr_addr : req.wr_addr[XA_W-1:0];
  assign wdata = clearing ? '0 : req.wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == XA_W'(XR_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr[XA_W-1:0]];
    end
  end

endmodule

@@ rtl/vrp_vram.sv @@
// video memory with address folding and registered read
module vrp_vram
  import vrp_pkg::*;
#(
  parameter int VRAM_WORDS = VRAM_WORDS_DEF
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  localparam int  VA_W = $clog2(VRAM_WORDS);
  localparam bit  POW2 = (VRAM_WORDS & (VRAM_WORDS - 1)) == 0;

  logic [DATA_W-1:0] mem [VRAM_WORDS];
  logic [VA_W-1:0]   rd_idx, wr_idx;

  // reduce a 16-bit address below the depth, for a quotient of at most 127
  function automatic logic [15:0] fold(input logic [15:0] a);
    logic [22:0] rem;
    rem = 23'(a);
    for (int k = 6; k >= 0; k--) begin
      if (rem >= (23'(VRAM_WORDS) << k)) begin
        rem = rem - (23'(VRAM_WORDS) << k);
      end
    end
    return rem[15:0];
  endfunction

  generate
    if (POW2) begin : g_mask
      assign rd_idx = req.rd_addr[VA_W-1:0];
      assign wr_idx = req.wr_addr[VA_W-1:0];
    end else begin : g_fold
      logic [15:0] rd_f, wr_f;
      assign rd_f   = fold(req.rd_addr);
      assign wr_f   = fold(req.wr_addr);
      assign rd_idx = rd_f[VA_W-1:0];
      assign wr_idx = wr_f[VA_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_idx] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

endmodule

@@ rtl/vrp_out.sv @@
// result register and read data selection
module vrp_out
  import vrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  res_t              res,
  input  logic [DATA_W-1:0] xr_rdata,
  input  logic [DATA_W-1:0] vr_rdata,
  vrp_out_if.source         rsp
);

  res_t              held;
  logic [DATA_W-1:0] word;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= res;
    end
  end

  always_comb begin
    case (held.src)
      SRC_XR:   word = xr_rdata;
      SRC_VRAM: word = vr_rdata;
      default:  word = held.value;
    endcase
    case (held.bmode)
      BM_HI:   rsp.read_data = {8'h00, word[15:8]};
      BM_LO:   rsp.read_data = {8'h00, word[7:0]};
      default: rsp.read_data = word;
    endcase
  end

  assign rsp.status = held.status;

endmodule
